### rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Types, codes and constants shared by the piecewise linear interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

   // Breakpoint table geometry
   localparam int MAX_POINTS = 16;
   localparam int PTR_W      = $clog2(MAX_POINTS);
   localparam int PTS_W      = 5;

   // Arithmetic widths: differences are 33 bits, their product 66 bits
   localparam int DIFF_W       = 33;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int DIV_BITS     = 2;
   localparam int DIV_CYCLES   = PROD_W / DIV_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   // Request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Response status codes
   localparam logic [1:0] STAT_INTERP = 2'd0;
   localparam logic [1:0] STAT_BELOW  = 2'd1;
   localparam logic [1:0] STAT_ABOVE  = 2'd2;
   localparam logic [1:0] STAT_DEGEN  = 2'd3;

   typedef struct packed {
      logic               opcode;
      logic [3:0]         entry_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interp_value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_LAST,
      ST_FIRST,
      ST_SCAN,
      ST_PREP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV,
      ST_RND,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_CAPTURE,
      DP_ISSUE,
      DP_LAST,
      DP_FIRST,
      DP_SCAN,
      DP_PREP,
      DP_MUL_LO,
      DP_MUL_HI,
      DP_DIV,
      DP_RND,
      DP_FIN
   } dp_op_type;

   typedef struct packed {
      logic gt_last;
      logic hit;
      logic den_zero;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/piecewise_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Load request: written in the accept cycle, busy stays low, no response.
// Query request: a response strobe follows the first and last entry checks when
// above range, the table scan for a degenerate segment, and otherwise the scan,
// multiply, divide, round and saturate steps; the next request is taken the
// cycle after the strobe. The scan reads one entry per cycle on the single
// memory read port; the divider is radix-4. Synchronous reset: idle, point
// count 2, table contents undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator_top import pli_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [PTS_W-1:0] csr_wdata
);

   dp_op_type     dp_op;
   dp_status_type dp_status;
   logic          csr_we;

   assign csr_ready = ~busy;
   assign csr_we    = csr_valid & csr_ready;

   pli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_payload.opcode),
      .dp_status  (dp_status),
      .dp_op      (dp_op),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   pli_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .dp_op       (dp_op),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .dp_status   (dp_status),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### rtl/pli_dpath.sv
// ----------------------------------------------------------------------------
// pli_dpath
// Breakpoint memory, segment scan registers, shared multiplier, radix-4
// restoring divider and the rounding/saturation stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_dpath import pli_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dp_op_type        dp_op,
   input  wire req_type          req_payload,
   input  wire logic             csr_we,
   input  wire logic [PTS_W-1:0] csr_wdata,
   output dp_status_type         dp_status,
   output rsp_type               rsp_payload
);

   localparam int MUL_SPLIT = (DIFF_W + 1) / 2;

   function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
   endfunction

   logic signed [31:0] mem_x [MAX_POINTS];
   logic signed [31:0] mem_y [MAX_POINTS];

   logic [PTS_W-1:0]   pts_ff, pts_in;
   logic [PTR_W-1:0]   addr_ff, addr_in;
   logic signed [31:0] rd_x_ff, rd_y_ff;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [31:0] qx_ff, qx_in;
   logic               below_ff, below_in;
   logic               above_ff, above_in;
   logic [DIFF_W-1:0]  dxq_ff, dxq_in, dy_ff, dy_in, den_ff, den_in;
   logic signed [31:0] ys_ff, ys_in;
   logic [1:0]         base_stat_ff, base_stat_in;
   logic [DIFF_W-1:0]  mag_a_ff, mag_a_in, mag_b_ff, mag_b_in, mag_d_ff, mag_d_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [DIFF_W-1:0]  rem_ff, rem_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0]         stat_ff, stat_in;

   logic [PTR_W-1:0]          last_addr;
   logic [MUL_SPLIT-1:0]      mul_sel;
   logic [DIFF_W+MUL_SPLIT-1:0] prod;
   logic [DIFF_W:0]           t1, t2, r1, r2, den_ext;
   logic                      ge1, ge2, round_up, big;
   logic [34:0]               ys35, q35, sum35;

   // Index of the last breakpoint in use, point count clamped to 2..MAX_POINTS
   always_comb begin
      if (int'(pts_ff) < 2) begin
         last_addr = PTR_W'(1);
      end else if (int'(pts_ff) > MAX_POINTS) begin
         last_addr = PTR_W'(MAX_POINTS - 1);
      end else begin
         last_addr = PTR_W'(pts_ff - PTS_W'(1));
      end
   end

   always_comb begin
      pts_in = csr_we ? csr_wdata : pts_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pts_ff <= PTS_W'(2);
      end else begin
         pts_ff <= pts_in;
      end
   end

   // Breakpoint memory, one registered read port
   always_ff @(posedge clock) begin
      if (dp_op == DP_LOAD) begin
         mem_x[PTR_W'(req_payload.entry_index)] <= req_payload.point_x;
         mem_y[PTR_W'(req_payload.entry_index)] <= req_payload.point_y;
      end
      rd_x_ff <= mem_x[addr_ff];
      rd_y_ff <= mem_y[addr_ff];
   end

   // above range only counts once the first entry rules out extrapolation below
   assign dp_status.gt_last  = above_ff && !(qx_ff < rd_x_ff);
   assign dp_status.hit      = below_ff || (rd_x_ff >= qx_ff);
   assign dp_status.den_zero = (den_ff == '0);

   // Shared multiplier: low then high half of |dy|
   always_comb begin
      if (dp_op == DP_MUL_HI) begin
         mul_sel = MUL_SPLIT'(mag_b_ff[DIFF_W-1:MUL_SPLIT]);
      end else begin
         mul_sel = mag_b_ff[MUL_SPLIT-1:0];
      end
      prod = mag_a_ff * mul_sel;
   end

   // Two restoring division steps per cycle
   always_comb begin
      den_ext = {1'b0, mag_d_ff};
      t1  = {rem_ff, acc_ff[PROD_W-1]};
      ge1 = t1 >= den_ext;
      r1  = ge1 ? (t1 - den_ext) : t1;
      t2  = {r1[DIFF_W-1:0], acc_ff[PROD_W-2]};
      ge2 = t2 >= den_ext;
      r2  = ge2 ? (t2 - den_ext) : t2;
      round_up = {rem_ff, 1'b0} >= den_ext;
   end

   // Final add of ys and saturation
   always_comb begin
      big   = |acc_ff[PROD_W-1:DIFF_W];
      ys35  = {{3{ys_ff[31]}}, ys_ff};
      q35   = {2'b00, acc_ff[DIFF_W-1:0]};
      sum35 = neg_ff ? (ys35 - q35) : (ys35 + q35);
   end

   always_comb begin
      addr_in      = addr_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      qx_in        = qx_ff;
      below_in     = below_ff;
      above_in     = above_ff;
      dxq_in       = dxq_ff;
      dy_in        = dy_ff;
      den_in       = den_ff;
      ys_in        = ys_ff;
      base_stat_in = base_stat_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      mag_d_in     = mag_d_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      unique case (dp_op)
         DP_CAPTURE: begin
            qx_in   = req_payload.query_x;
            addr_in = last_addr;
         end
         DP_ISSUE: begin
            addr_in = '0;
         end
         DP_LAST: begin
            addr_in  = addr_ff + PTR_W'(1);
            above_in = qx_ff > rd_x_ff;
         end
         DP_FIRST: begin
            addr_in   = addr_ff + PTR_W'(1);
            prev_x_in = rd_x_ff;
            prev_y_in = rd_y_ff;
            below_in  = qx_ff < rd_x_ff;
            if (dp_status.gt_last) begin
               res_in  = ONE_Q16;
               stat_in = STAT_ABOVE;
            end
         end
         DP_SCAN: begin
            if (dp_status.hit) begin
               // rd holds the segment end, prev its start
               dxq_in       = {qx_ff[31], qx_ff} - {prev_x_ff[31], prev_x_ff};
               dy_in        = {rd_y_ff[31], rd_y_ff} - {prev_y_ff[31], prev_y_ff};
               den_in       = {rd_x_ff[31], rd_x_ff} - {prev_x_ff[31], prev_x_ff};
               ys_in        = prev_y_ff;
               base_stat_in = below_ff ? STAT_BELOW : STAT_INTERP;
            end else begin
               addr_in   = addr_ff + PTR_W'(1);
               prev_x_in = rd_x_ff;
               prev_y_in = rd_y_ff;
            end
         end
         DP_PREP: begin
            mag_a_in = mag(dxq_ff);
            mag_b_in = mag(dy_ff);
            mag_d_in = mag(den_ff);
            neg_in   = dxq_ff[DIFF_W-1] ^ dy_ff[DIFF_W-1] ^ den_ff[DIFF_W-1];
            res_in   = ys_ff;
            stat_in  = STAT_DEGEN;
         end
         DP_MUL_LO: begin
            acc_in = PROD_W'(prod);
         end
         DP_MUL_HI: begin
            acc_in = acc_ff + (PROD_W'(prod) << MUL_SPLIT);
            rem_in = '0;
         end
         DP_DIV: begin
            acc_in = {acc_ff[PROD_W-3:0], ge1, ge2};
            rem_in = r2[DIFF_W-1:0];
         end
         DP_RND: begin
            acc_in = acc_ff + PROD_W'(round_up);
         end
         DP_FIN: begin
            stat_in = base_stat_ff;
            if (big) begin
               res_in = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else if ($signed(sum35) > $signed({3'b000, 32'h7FFF_FFFF})) begin
               res_in = 32'sh7FFF_FFFF;
            end else if ($signed(sum35) < $signed({3'b111, 32'h8000_0000})) begin
               res_in = 32'sh8000_0000;
            end else begin
               res_in = sum35[31:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      qx_ff        <= qx_in;
      below_ff     <= below_in;
      above_ff     <= above_in;
      dxq_ff       <= dxq_in;
      dy_ff        <= dy_in;
      den_ff       <= den_in;
      ys_ff        <= ys_in;
      base_stat_ff <= base_stat_in;
      mag_a_ff     <= mag_a_in;
      mag_b_ff     <= mag_b_in;
      mag_d_ff     <= mag_d_in;
      neg_ff       <= neg_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      res_ff       <= res_in;
      stat_ff      <= stat_in;
   end

   assign rsp_payload.interp_value = res_ff;
   assign rsp_payload.status       = stat_ff;

endmodule

`default_nettype wire

### rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for one request: loads are issued at once; a query runs table scan, multiply, divide, round, respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_ctrl import pli_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_opcode,
   input  wire dp_status_type dp_status,
   output dp_op_type          dp_op,
   output logic               busy,
   output logic               rsp_valid
);

   state_type             state_ff, state_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  div_last;

   assign div_last = (div_cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));

   always_comb begin
      div_cnt_in = (state_ff == ST_DIV) ? (div_cnt_ff + DIV_CNT_W'(1)) : '0;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_opcode == OP_QUERY)) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE:  state_in = ST_LAST;
         ST_LAST:   state_in = ST_FIRST;
         // below the first entry wins over above the last one
         ST_FIRST:  state_in = dp_status.gt_last ? ST_DONE : ST_SCAN;
         ST_SCAN:   state_in = dp_status.hit ? ST_PREP : ST_SCAN;
         ST_PREP:   state_in = dp_status.den_zero ? ST_DONE : ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_DIV;
         ST_DIV:    state_in = div_last ? ST_RND : ST_DIV;
         ST_RND:    state_in = ST_FIN;
         ST_FIN:    state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_IDLE: begin
            if (!start) begin
               dp_op = DP_NOP;
            end else if (req_opcode == OP_QUERY) begin
               dp_op = DP_CAPTURE;
            end else begin
               dp_op = DP_LOAD;
            end
         end
         ST_ISSUE:  dp_op = DP_ISSUE;
         ST_LAST:   dp_op = DP_LAST;
         ST_FIRST:  dp_op = DP_FIRST;
         ST_SCAN:   dp_op = DP_SCAN;
         ST_PREP:   dp_op = DP_PREP;
         ST_MUL_LO: dp_op = DP_MUL_LO;
         ST_MUL_HI: dp_op = DP_MUL_HI;
         ST_DIV:    dp_op = DP_DIV;
         ST_RND:    dp_op = DP_RND;
         ST_FIN:    dp_op = DP_FIN;
         default:   dp_op = DP_NOP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pli_checker import pli_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_payload
);

   // response is a single-cycle strobe
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("not idle after reset");

   // a query keeps the block busy, a load does not
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.opcode == OP_QUERY)) |=> busy)
      else $error("query request did not raise busy");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.opcode == OP_LOAD)) |=> (!busy && !rsp_valid))
      else $error("load request produced activity");

   a_above_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status == STAT_ABOVE)) |->
         (rsp_payload.interp_value == ONE_Q16))
      else $error("above-range response is not 1.0");

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
